### hw/rtl/bslp_pkg.sv
// ----------------------------------------------------------------------------
// bslp_pkg
// Shared types, constants and helpers of the button short/long press detector.
// ----------------------------------------------------------------------------
package bslp_pkg;

    localparam int NUM_BUTTONS = 7;
    localparam int COUNT_WIDTH = 16;
    // Button index wide enough to also hold the "no button" code.
    localparam int BTN_W       = $clog2(NUM_BUTTONS + 1);
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_IDX_W   = 3;

    localparam logic [BTN_W-1:0] NO_BUTTON = BTN_W'(NUM_BUTTONS);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LONG_PRESS_TICKS  = 3'd0,
        REG_MIN_PRESS_TICKS   = 3'd1,
        REG_SHORT_ENABLE_MASK = 3'd2,
        REG_LONG_ENABLE_MASK  = 3'd3,
        REG_CONTINUE_MASK     = 3'd4
    } cfg_index_t;

    localparam logic [15:0]            RST_LONG_PRESS_TICKS  = 16'd100;
    localparam logic [15:0]            RST_MIN_PRESS_TICKS   = 16'd2;
    localparam logic [NUM_BUTTONS-1:0] RST_SHORT_ENABLE_MASK = NUM_BUTTONS'(63);
    localparam logic [NUM_BUTTONS-1:0] RST_LONG_ENABLE_MASK  = NUM_BUTTONS'(127);
    localparam logic [NUM_BUTTONS-1:0] RST_CONTINUE_MASK     = NUM_BUTTONS'(63);

    typedef struct packed {
        logic [15:0]            long_press_ticks;
        logic [15:0]            min_press_ticks;
        logic [NUM_BUTTONS-1:0] short_enable_mask;
        logic [NUM_BUTTONS-1:0] long_enable_mask;
        logic [NUM_BUTTONS-1:0] continue_mask;
    } cfg_t;

    typedef enum logic [4:0] {
        PH_INIT    = 5'b00001,
        PH_IDLE    = 5'b00010,
        PH_PRESS   = 5'b00100,
        PH_RELEASE = 5'b01000,
        PH_LONG    = 5'b10000
    } phase_t;

    typedef struct packed {
        logic             fire;
        logic [BTN_W-1:0] button_index;
        logic             is_long;
    } result_t;

    // Mask lookup; the "no button" code and anything above reads as disabled.
    function automatic logic mask_bit(logic [NUM_BUTTONS-1:0] mask, logic [BTN_W-1:0] idx);
        logic [(1 << BTN_W)-1:0] wide;
        wide = (1 << BTN_W)'(mask);
        return wide[idx];
    endfunction

endpackage

### hw/rtl/bslp_if.sv
// ----------------------------------------------------------------------------
// bslp_if
// Valid/ready channels of the press detector: button word in, event word out.
// ----------------------------------------------------------------------------
interface bslp_in_if;
    logic                            valid;
    logic                            ready;
    logic [bslp_pkg::NUM_BUTTONS-1:0] button_levels;

    modport source (output valid, output button_levels, input ready);
    modport sink   (input valid, input button_levels, output ready);
endinterface

interface bslp_out_if;
    logic                       valid;
    logic                       ready;
    logic                       fire;
    logic [bslp_pkg::BTN_W-1:0] button_index;
    logic                       is_long;

    modport source (output valid, output fire, output button_index, output is_long, input ready);
    modport sink   (input valid, input fire, input button_index, input is_long, output ready);
endinterface

### hw/rtl/button_short_long_press_detector.sv
// ----------------------------------------------------------------------------
// button_short_long_press_detector
// Turns sampled active-low button levels into short and long press events.
// ----------------------------------------------------------------------------
// Usage: every word on the input channel is one sampling tick carrying the raw
// levels of all buttons. Each input word yields exactly one output word:
// fire, button_index and is_long, with fire low on ticks without an event.
// A tick is registered on acceptance, processed by the phase machine once the
// result register is free or emptying, and its result is held in the result
// register. With a ready receiver the block takes one word every cycle; the
// input register and the result register let a new word be accepted while a
// finished result still waits to be taken. If the receiver stalls, the result
// register holds its word, the input register fills, and input ready drops
// until the receiver takes the result. Reset puts the machine into its init
// phase, clears the press count, marks no button held and loads the default
// thresholds and masks. The user writes registers via cfg_write/cfg_index/
// cfg_data only while no tick is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module button_short_long_press_detector (
    input  logic                             clk,
    input  logic                             rst_n,
    bslp_in_if.sink                          in_ch,
    bslp_out_if.source                       out_ch,
    input  logic                             cfg_write,
    input  logic [bslp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bslp_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import bslp_pkg::*;

    cfg_t                   cfg;
    result_t                result;
    logic                   s1_valid_reg, s1_valid_next;
    logic [NUM_BUTTONS-1:0] s1_levels_reg;
    logic                   out_valid_reg, out_valid_next;
    result_t                out_reg;
    logic                   advance;
    logic                   in_take;

    bslp_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bslp_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .levels (s1_levels_reg),
        .cfg    (cfg),
        .result (result)
    );

    // The registered tick moves on when the result register is free or emptying.
    assign advance      = s1_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready  = !s1_valid_reg || advance;
    assign in_take      = in_ch.valid && in_ch.ready;

    assign s1_valid_next  = in_take || (s1_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !out_ch.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            s1_levels_reg <= in_ch.button_levels;
        if (advance)
            out_reg <= result;
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.fire         = out_reg.fire;
    assign out_ch.button_index = out_reg.button_index;
    assign out_ch.is_long      = out_reg.is_long;

endmodule

### hw/rtl/bslp_cfg_regs.sv
// ----------------------------------------------------------------------------
// bslp_cfg_regs
// Configuration register file; writes beyond the register list are dropped.
// ----------------------------------------------------------------------------
module bslp_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [bslp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bslp_pkg::CFG_DATA_W-1:0]  cfg_data,
    output bslp_pkg::cfg_t                   cfg
);
    import bslp_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_LONG_PRESS_TICKS:  cfg_next.long_press_ticks  = cfg_data;
                REG_MIN_PRESS_TICKS:   cfg_next.min_press_ticks   = cfg_data;
                REG_SHORT_ENABLE_MASK: cfg_next.short_enable_mask = cfg_data[NUM_BUTTONS-1:0];
                REG_LONG_ENABLE_MASK:  cfg_next.long_enable_mask  = cfg_data[NUM_BUTTONS-1:0];
                REG_CONTINUE_MASK:     cfg_next.continue_mask     = cfg_data[NUM_BUTTONS-1:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.long_press_ticks  <= RST_LONG_PRESS_TICKS;
            cfg_reg.min_press_ticks   <= RST_MIN_PRESS_TICKS;
            cfg_reg.short_enable_mask <= RST_SHORT_ENABLE_MASK;
            cfg_reg.long_enable_mask  <= RST_LONG_ENABLE_MASK;
            cfg_reg.continue_mask     <= RST_CONTINUE_MASK;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### hw/rtl/bslp_core.sv
// ----------------------------------------------------------------------------
// bslp_core
// Priority scan and press phase machine; advances one tick when step is high.
// ----------------------------------------------------------------------------
module bslp_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               step,
    input  logic [bslp_pkg::NUM_BUTTONS-1:0]   levels,
    input  bslp_pkg::cfg_t                     cfg,
    output bslp_pkg::result_t                  result
);
    import bslp_pkg::*;

    phase_t                 phase_reg,  phase_next;
    logic [BTN_W-1:0]       held_reg,   held_next;
    logic [COUNT_WIDTH-1:0] count_reg,  count_next;
    logic [BTN_W-1:0]       pressed;
    logic [COUNT_WIDTH-1:0] count_inc;

    // Lowest pressed button wins; lines are active low.
    always_comb
    begin
        pressed = NO_BUTTON;
        for (int i = NUM_BUTTONS - 1; i >= 0; i--)
        begin
            if (!levels[i])
                pressed = BTN_W'(i);
        end
    end

    assign count_inc = (count_reg == COUNT_MAX) ? count_reg : count_reg + 1'b1;

    always_comb
    begin
        phase_next = phase_reg;
        held_next  = held_reg;
        count_next = count_reg;
        result     = '0;
        unique case (phase_reg)
            PH_IDLE:
            begin
                held_next = pressed;
                if (pressed != NO_BUTTON)
                    phase_next = PH_PRESS;
            end
            PH_PRESS:
            begin
                count_next = count_inc;
                // Release takes priority over reaching the long threshold.
                if (pressed == NO_BUTTON)
                    phase_next = PH_RELEASE;
                else if (count_inc >= cfg.long_press_ticks)
                    phase_next = PH_LONG;
            end
            PH_LONG:
            begin
                if (mask_bit(cfg.long_enable_mask, held_reg))
                begin
                    result.fire         = 1'b1;
                    result.button_index = held_reg;
                    result.is_long      = 1'b1;
                end
                if (pressed == NO_BUTTON || !mask_bit(cfg.continue_mask, held_reg))
                begin
                    phase_next = PH_IDLE;
                    count_next = '0;
                end
            end
            PH_RELEASE:
            begin
                if (count_reg > cfg.min_press_ticks && mask_bit(cfg.short_enable_mask, held_reg))
                begin
                    result.fire         = 1'b1;
                    result.button_index = held_reg;
                end
                phase_next = PH_IDLE;
                count_next = '0;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_INIT;
            held_reg  <= NO_BUTTON;
            count_reg <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
            count_reg <= count_next;
        end
    end

endmodule
